@@ src/bmrj_pkg.sv @@
// Package for the block map with rollback journal.
// Holds sizes, field widths, opcodes, status codes and the packed item types.
// Used by block_map_with_rollback_journal.
package bmrj_pkg;

   localparam int BLOCKS            = 4096;
   localparam int SECTORS_PER_BLOCK = 8;
   localparam int JOURNAL_DEPTH     = 1024;
   localparam int MAX_RUN           = 64;

   localparam int BLK_W  = $clog2(BLOCKS);
   localparam int JRN_W  = $clog2(JOURNAL_DEPTH);
   localparam int TOP_W  = $clog2(JOURNAL_DEPTH + 1);
   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int SPB_SH = $clog2(SECTORS_PER_BLOCK);

   localparam int OP_W   = 2;
   localparam int LBA_W  = 15;
   localparam int SECS_W = 10;
   localparam int CNT_W  = 11;
   localparam int SLOT_W = 32;
   localparam int ST_W   = 3;
   localparam int DISK_W = 13;
   localparam int OBLK_W = 12;

   // Sector sum and block-end widths for the range decode.
   localparam int SUM_W  = LBA_W + 1;
   localparam int EBLK_W = SUM_W - SPB_SH;

   localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
   localparam logic [OP_W-1:0] OP_READ     = 2'd1;
   localparam logic [OP_W-1:0] OP_ROLLBACK = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_UNMAPPED = 3'd1;
   localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
   localparam logic [ST_W-1:0] ST_LONG     = 3'd4;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [LBA_W-1:0]  lba;
      logic [SECS_W-1:0] secs;
      logic [CNT_W-1:0]  rollback_count;
   } req_item_type;

   typedef struct packed {
      logic [OBLK_W-1:0] block;
      logic [SLOT_W-1:0] log_slot;
      logic [ST_W-1:0]   status;
      logic [CNT_W-1:0]  rolled_back;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   typedef struct packed {
      logic [BLK_W-1:0]  blk;
      logic              prev_valid;
      logic [SLOT_W-1:0] prev_slot;
   } jrn_entry_type;

endpackage

@@ src/block_map_with_rollback_journal.sv @@
// Block map with rollback journal: a sequencer around a map RAM and a journal RAM.
// After acceptance a read or write decodes, then per block does a map read, then emits the
// result (writing map and journal for a write). A rollback does a journal read and map restore
// per popped entry, a clear the clearing pass; both, and a rejected item, then emit a result.
// All wait out any result stall; the next item is accepted in the idle cycle after. Reset and
// a clear run a clearing pass over the map RAM with the input stalled; csr writes go any time.
module block_map_with_rollback_journal
   import bmrj_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [DISK_W-1:0]  csr_data
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_CHECK   = 8'b0000_0010,
      S_MAP_RD  = 8'b0000_0100,
      S_MAP_USE = 8'b0000_1000,
      S_RB_RD   = 8'b0001_0000,
      S_RB_USE  = 8'b0010_0000,
      S_CLEAR   = 8'b0100_0000,
      S_EMIT    = 8'b1000_0000
   } state_type;

   localparam logic [SLOT_W:0] SLOT_LIMIT = {1'b1, {SLOT_W{1'b0}}};

   state_type          state_ff, state_in;
   req_item_type       req_ff, req_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;
   rsp_item_type       pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DISK_W-1:0]  disk_ff, disk_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   logic [SLOT_W-1:0]  next_slot_ff, next_slot_in;
   logic [BLK_W-1:0]   cur_blk_ff, cur_blk_in;
   logic [RUN_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   popped_ff, popped_in;
   logic               was_empty_ff, was_empty_in;
   logic [BLK_W-1:0]   clr_ff, clr_in;
   logic               clr_report_ff, clr_report_in;

   logic               map_wr_en, map_rd_en;
   logic [BLK_W-1:0]   map_wr_addr, map_rd_addr;
   map_entry_type      map_wr_data, map_rd_data;
   logic               jrn_wr_en, jrn_rd_en;
   logic [JRN_W-1:0]   jrn_wr_addr, jrn_rd_addr;
   jrn_entry_type      jrn_wr_data, jrn_rd_data;

   // Range decode of the held item.
   logic [SUM_W-1:0]   end_sec;
   logic [EBLK_W-1:0]  first_blk, end_blk, n_blk;
   logic [DISK_W-1:0]  lim;
   logic [RUN_W-1:0]   n_run;
   logic               jrn_full, slot_full;
   logic               out_free, push;
   rsp_item_type       push_item;

   bmrj_ram #(.WIDTH($bits(map_entry_type)), .DEPTH(BLOCKS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   bmrj_ram #(.WIDTH($bits(jrn_entry_type)), .DEPTH(JOURNAL_DEPTH)) u_jrn_ram (
      .clock   (clock),
      .wr_en   (jrn_wr_en),
      .wr_addr (jrn_wr_addr),
      .wr_data (jrn_wr_data),
      .rd_en   (jrn_rd_en),
      .rd_addr (jrn_rd_addr),
      .rd_data (jrn_rd_data)
   );

   assign end_sec   = SUM_W'(req_ff.lba) + SUM_W'(req_ff.secs)
                      + SUM_W'(SECTORS_PER_BLOCK - 1);
   assign first_blk = EBLK_W'(req_ff.lba >> SPB_SH);
   assign end_blk   = EBLK_W'(end_sec >> SPB_SH);
   assign n_blk     = end_blk - first_blk;
   assign n_run     = n_blk[RUN_W-1:0];
   assign lim       = (disk_ff > DISK_W'(BLOCKS)) ? DISK_W'(BLOCKS) : disk_ff;
   assign jrn_full  = ((TOP_W + 1)'(top_ff) + (TOP_W + 1)'(n_run))
                      > (TOP_W + 1)'(JOURNAL_DEPTH);
   assign slot_full = ({1'b0, next_slot_ff} + (SLOT_W + 1)'(n_run)) > SLOT_LIMIT;

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      pend_in       = pend_ff;
      disk_in       = csr_valid ? csr_data : disk_ff;
      top_in        = top_ff;
      next_slot_in  = next_slot_ff;
      cur_blk_in    = cur_blk_ff;
      rem_in        = rem_ff;
      popped_in     = popped_ff;
      was_empty_in  = was_empty_ff;
      clr_in        = clr_ff;
      clr_report_in = clr_report_ff;
      push          = 1'b0;
      push_item     = '0;
      map_wr_en     = 1'b0;
      map_wr_addr   = cur_blk_ff;
      map_wr_data   = '0;
      map_rd_en     = 1'b0;
      map_rd_addr   = cur_blk_ff;
      jrn_wr_en     = 1'b0;
      jrn_wr_addr   = top_ff[JRN_W-1:0];
      jrn_wr_data   = '0;
      jrn_rd_en     = 1'b0;
      jrn_rd_addr   = top_ff[JRN_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_item;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            pend_in      = '0;
            pend_in.last = 1'b1;
            if (req_ff.op == OP_CLEAR) begin
               top_in        = '0;
               next_slot_in  = '0;
               clr_in        = '0;
               clr_report_in = 1'b1;
               state_in      = S_CLEAR;
            end else if (req_ff.op == OP_ROLLBACK) begin
               popped_in    = '0;
               was_empty_in = (top_ff == '0);
               state_in     = S_RB_RD;
            end else if (req_ff.secs == '0) begin
               pend_in.status = ST_EMPTY;
               state_in       = S_EMIT;
            end else if (n_blk > EBLK_W'(MAX_RUN)) begin
               pend_in.status = ST_LONG;
               state_in       = S_EMIT;
            end else if (DISK_W'(end_blk) > lim) begin
               pend_in.status = ST_RANGE;
               state_in       = S_EMIT;
            end else if (req_ff.op == OP_WRITE && (jrn_full || slot_full)) begin
               pend_in.status = ST_FULL;
               state_in       = S_EMIT;
            end else begin
               cur_blk_in = first_blk[BLK_W-1:0];
               rem_in     = n_run;
               state_in   = S_MAP_RD;
            end
         end

         S_MAP_RD: begin
            map_rd_en = 1'b1;
            state_in  = S_MAP_USE;
         end

         S_MAP_USE: begin
            // The map read data holds until the next read, so a stalled result just waits.
            if (out_free) begin
               push            = 1'b1;
               push_item.block = OBLK_W'(cur_blk_ff);
               push_item.last  = (rem_ff == RUN_W'(1));
               if (req_ff.op == OP_WRITE) begin
                  push_item.log_slot     = next_slot_ff;
                  push_item.status       = ST_OK;
                  map_wr_en              = 1'b1;
                  map_wr_data.valid      = 1'b1;
                  map_wr_data.slot       = next_slot_ff;
                  jrn_wr_en              = 1'b1;
                  jrn_wr_data.blk        = cur_blk_ff;
                  jrn_wr_data.prev_valid = map_rd_data.valid;
                  jrn_wr_data.prev_slot  = map_rd_data.slot;
                  top_in                 = top_ff + TOP_W'(1);
                  next_slot_in           = next_slot_ff + SLOT_W'(1);
               end else if (map_rd_data.valid) begin
                  push_item.log_slot = map_rd_data.slot;
                  push_item.status   = ST_OK;
               end else begin
                  push_item.log_slot = '0;
                  push_item.status   = ST_UNMAPPED;
               end
               if (rem_ff == RUN_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  cur_blk_in = cur_blk_ff + BLK_W'(1);
                  rem_in     = rem_ff - RUN_W'(1);
                  state_in   = S_MAP_RD;
               end
            end
         end

         S_RB_RD: begin
            if (popped_ff < req_ff.rollback_count && top_ff != '0) begin
               jrn_rd_en   = 1'b1;
               jrn_rd_addr = JRN_W'(top_ff - TOP_W'(1));
               top_in      = top_ff - TOP_W'(1);
               state_in    = S_RB_USE;
            end else begin
               pend_in             = '0;
               pend_in.rolled_back = popped_ff;
               pend_in.last        = 1'b1;
               pend_in.status      = (req_ff.rollback_count != '0 && was_empty_ff)
                                     ? ST_EMPTY : ST_OK;
               state_in            = S_EMIT;
            end
         end

         S_RB_USE: begin
            map_wr_en         = 1'b1;
            map_wr_addr       = jrn_rd_data.blk;
            map_wr_data.valid = jrn_rd_data.prev_valid;
            map_wr_data.slot  = jrn_rd_data.prev_slot;
            popped_in         = popped_ff + CNT_W'(1);
            state_in          = S_RB_RD;
         end

         S_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ff;
            map_wr_data = '0;
            clr_in      = clr_ff + BLK_W'(1);
            if (clr_ff == BLK_W'(BLOCKS - 1)) begin
               if (clr_report_ff) begin
                  pend_in      = '0;
                  pend_in.last = 1'b1;
                  state_in     = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               push      = 1'b1;
               push_item = pend_ff;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_item_in  = push ? push_item : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_valid_ff  <= 1'b0;
         disk_ff       <= DISK_W'(BLOCKS);
         top_ff        <= '0;
         next_slot_ff  <= '0;
         clr_ff        <= '0;
         clr_report_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         disk_ff       <= disk_in;
         top_ff        <= top_in;
         next_slot_ff  <= next_slot_in;
         clr_ff        <= clr_in;
         clr_report_ff <= clr_report_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_item_ff  <= rsp_item_in;
      pend_ff      <= pend_in;
      cur_blk_ff   <= cur_blk_in;
      rem_ff       <= rem_in;
      popped_ff    <= popped_in;
      was_empty_ff <= was_empty_in;
   end

endmodule

@@ src/bmrj_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing outside this file.
module bmrj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
